@@ rtl/gim_pkg.sv @@
// Shared types, codes and sizes for the graph incidence matrix store.
`default_nettype none

package gim_pkg;

	localparam int MAX_V = 16;
	localparam int MAX_E = 32;
	localparam int VW    = $clog2(MAX_V);
	localparam int EW    = $clog2(MAX_E);
	localparam int VCW   = VW + 1;
	localparam int ECW   = EW + 1;

	localparam logic [VCW-1:0] VCOUNT_RST = VCW'(MAX_V);
	localparam logic [ECW-1:0] ECOUNT_RST = ECW'(MAX_E);

	localparam logic [1:0] ACT_ADD      = 2'd0;
	localparam logic [1:0] ACT_DEGREE   = 2'd1;
	localparam logic [1:0] ACT_NEIGHBOR = 2'd2;
	localparam logic [1:0] ACT_ISOLATED = 2'd3;

	localparam logic [1:0] ENT_ZERO = 2'b00;
	localparam logic [1:0] ENT_POS  = 2'b01;
	localparam logic [1:0] ENT_NEG  = 2'b11;

	localparam logic [1:0] REG_DIRECTED = 2'd0;
	localparam logic [1:0] REG_VCOUNT   = 2'd1;
	localparam logic [1:0] REG_ECOUNT   = 2'd2;

	typedef logic [1:0] ent_t;
	typedef ent_t [MAX_V-1:0] col_t;

	typedef struct packed {
		logic [1:0]    action;
		logic [VW-1:0] first_vertex;
		logic [VW-1:0] second_vertex;
		logic [EW-1:0] edge_slot;
	} req_t;

	typedef struct packed {
		logic [ECW-1:0] degree_count;
		logic [VW-1:0]  neighbor_vertex;
		logic           neighbor_found;
		logic           vertex_isolated;
		logic           index_error;
		logic           last_result;
	} rsp_t;

	typedef struct packed {
		logic           directed;
		logic [VCW-1:0] n_act;
		logic [ECW-1:0] m_act;
	} cfg_t;

	typedef struct packed {
		logic item_load;
		logic add_rd;
		logic add_wr;
		logic scan_rd;
		logic scan_step;
		logic emit_pend;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic       err;
		logic [1:0] act;
		logic       j_done;
		logic       nb_hit;
		logic       pend_vld;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/graph_incidence_matrix_store.sv @@
// Graph incidence matrix store: top level with configuration registers.
// Add edge: decode, column read, column write and result steps from accept to next accept.
// Queries: decode, then for each of the m edge columns in use one memory read and one
// evaluate step on the single column memory port, then the result step. The result step,
// and an evaluate step that must send out a held neighbour, wait while the output is stalled.
// Reset clears the matrix at once through per-column valid bits; no clearing pass.
`default_nettype none

module graph_incidence_matrix_store import gim_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp
);

	logic           directed_q;
	logic [VCW-1:0] vcount_q;
	logic [ECW-1:0] ecount_q;
	logic           wr_en;
	cfg_t           cfg;
	cmd_t           cmd;
	sts_t           sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			directed_q <= 1'b0;
			vcount_q   <= VCOUNT_RST;
			ecount_q   <= ECOUNT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DIRECTED: directed_q <= pwdata[0];
				REG_VCOUNT:   vcount_q   <= pwdata[VCW-1:0];
				REG_ECOUNT:   ecount_q   <= pwdata[ECW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_DIRECTED: prdata = {31'd0, directed_q};
			REG_VCOUNT:   prdata = {{(32-VCW){1'b0}}, vcount_q};
			REG_ECOUNT:   prdata = {{(32-ECW){1'b0}}, ecount_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.directed = directed_q;
	assign cfg.n_act    = (vcount_q > VCOUNT_RST) ? VCOUNT_RST : vcount_q;
	assign cfg.m_act    = (ecount_q > ECOUNT_RST) ? ECOUNT_RST : ecount_q;

	gim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gim_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ rtl/gim_ctrl.sv @@
// Sequencing state machine for the incidence matrix store.
`default_nettype none

module gim_ctrl import gim_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_ADD_RD  = 3'd2;
	localparam logic [2:0] S_ADD_WR  = 3'd3;
	localparam logic [2:0] S_SCAN_RD = 3'd4;
	localparam logic [2:0] S_SCAN_EV = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0] state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.err) begin
					state_d = S_FIN;
				end else if (sts.act == ACT_ADD) begin
					state_d = S_ADD_RD;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_ADD_RD: begin
				cmd.add_rd = 1'b1;
				state_d    = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_FIN;
			end
			S_SCAN_RD: begin
				if (sts.j_done) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				// a held neighbour goes out before the new one replaces it
				if (!(sts.nb_hit && sts.pend_vld && !sts.out_free)) begin
					cmd.scan_step = 1'b1;
					cmd.emit_pend = sts.nb_hit && sts.pend_vld;
					state_d       = S_SCAN_RD;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gim_dp.sv @@
// Datapath: column memory, scan counters, neighbour pick and result register.
`default_nettype none

module gim_dp import gim_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire req_t req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	col_t             mem [MAX_E];
	logic [MAX_E-1:0] col_vld_q;
	col_t             rdata_s1;
	logic             rd_vld_s1;

	req_t             item_q;
	logic             err_q;
	logic [ECW-1:0]   j_q;
	logic [ECW-1:0]   deg_q;
	logic             iso_q;
	logic [VW-1:0]    pend_q;
	logic             pend_vld_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             rd_en;
	logic [EW-1:0]    rd_addr;
	col_t             col;
	col_t             wcol;
	ent_t             ent;
	logic             hit;
	logic [MAX_V-1:0] cand;
	logic [VW-1:0]    nb;
	logic             found;
	logic             deg_inc;
	logic             err_in;
	logic             out_free;
	rsp_t             res;

	assign err_in = ({1'b0, req.first_vertex} >= cfg.n_act) ||
		((req.action == ACT_ADD) &&
		 (({1'b0, req.second_vertex} >= cfg.n_act) ||
		  ({1'b0, req.edge_slot} >= cfg.m_act)));

	assign rd_en   = cmd.add_rd || cmd.scan_rd;
	assign rd_addr = cmd.add_rd ? item_q.edge_slot : j_q[EW-1:0];

	assign col = rd_vld_s1 ? rdata_s1 : '0;
	assign ent = col[item_q.first_vertex];
	assign hit = (ent != ENT_ZERO);
	assign deg_inc = hit && (!cfg.directed || ent == ENT_POS);

	always_comb begin
		wcol = col;
		wcol[item_q.first_vertex]  = ENT_POS;
		wcol[item_q.second_vertex] = cfg.directed ? ENT_NEG : ENT_POS;
	end

	always_comb begin
		nb = '0;
		for (int i = 0; i < MAX_V; i++) begin
			cand[i] = (col[i] != ENT_ZERO) && (VW'(i) != item_q.first_vertex) &&
				(VCW'(i) < cfg.n_act);
		end
		for (int i = MAX_V - 1; i >= 0; i--) begin
			if (cand[i]) begin
				nb = VW'(i);
			end
		end
		found = |cand;
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	assign sts.err      = err_q;
	assign sts.act      = item_q.action;
	assign sts.j_done   = (j_q >= cfg.m_act);
	assign sts.nb_hit   = (item_q.action == ACT_NEIGHBOR) && hit && found;
	assign sts.pend_vld = pend_vld_q;
	assign sts.out_free = out_free;

	always_comb begin
		res = '0;
		if (cmd.emit_pend) begin
			res.neighbor_vertex = pend_q;
			res.neighbor_found  = 1'b1;
		end else begin
			res.last_result = 1'b1;
			if (err_q) begin
				res.index_error = 1'b1;
			end else begin
				case (item_q.action)
					ACT_DEGREE:   res.degree_count = deg_q;
					ACT_ISOLATED: res.vertex_isolated = iso_q;
					ACT_NEIGHBOR: begin
						res.neighbor_vertex = pend_vld_q ? pend_q : '0;
						res.neighbor_found  = pend_vld_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			mem[item_q.edge_slot] <= wcol;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1  <= mem[rd_addr];
			rd_vld_s1 <= col_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= req;
			err_q  <= err_in;
		end
		if (cmd.scan_step && sts.nb_hit) begin
			pend_q <= nb;
		end
		if (cmd.emit_pend || cmd.emit_final) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_vld_q   <= '0;
			j_q         <= '0;
			deg_q       <= '0;
			iso_q       <= 1'b1;
			pend_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.add_wr) begin
				col_vld_q[item_q.edge_slot] <= 1'b1;
			end
			if (cmd.item_load) begin
				j_q        <= '0;
				deg_q      <= '0;
				iso_q      <= 1'b1;
				pend_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				j_q <= j_q + ECW'(1);
				if (deg_inc) begin
					deg_q <= deg_q + ECW'(1);
				end
				if (hit) begin
					iso_q <= 1'b0;
				end
				if (sts.nb_hit) begin
					pend_vld_q <= 1'b1;
				end
			end
			if (cmd.emit_pend || cmd.emit_final) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ rtl/gim_checker.sv @@
// Port-level checks for the incidence matrix store, bound to the top level.
`default_nettype none

module gim_checker import gim_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item taken while previous still in work");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.index_error |-> rsp.last_result && !rsp.neighbor_found &&
			rsp.degree_count == '0 && !rsp.vertex_isolated)
		else $error("error item not alone");

	a_nb_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.neighbor_found |-> rsp.degree_count == '0 &&
			!rsp.vertex_isolated && !rsp.index_error)
		else $error("neighbour item mixes fields");

endmodule

bind graph_incidence_matrix_store gim_checker u_gim_checker (.*);

`default_nettype wire

@@ verif/tb_graph_incidence_matrix_store.sv @@
// Self-checking testbench for the graph incidence matrix store: directed table, then random phases.
`timescale 1ns / 1ps

module tb_graph_incidence_matrix_store;
	import gim_pkg::*;

	localparam int CYCLE_LIMIT  = 5000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RESULT_CAP   = 32;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [31:0] value;
		req_t        item;
		bit          typed;
		rsp_t        want;
	} plan_row_t;

	typedef struct {
		bit directed;
		int vcount;
		int ecount;
		int items;
		bit calm;
	} setting_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	ent_t incidence [MAX_V][MAX_E];
	bit   model_directed;
	int   model_vcount;
	int   model_ecount;
	rsp_t expected_rsps [$];

	int fail_count;
	int item_count;
	int rsp_count;
	int error_count;
	int longest_list;
	int setting_count;
	int cycle_count = 0;
	int stall_hold = 0;
	bit calm;

	graph_incidence_matrix_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic rsp_t done_rsp(bit iso, bit err);
		rsp_t r;
		r = '0;
		r.vertex_isolated = iso;
		r.index_error = err;
		r.last_result = 1'b1;
		return r;
	endfunction

	function automatic plan_row_t op(logic [1:0] act, int a, int b, int s);
		plan_row_t p;
		p.kind = ROW_ITEM;
		p.reg_idx = '0;
		p.value = '0;
		p.item.action = act;
		p.item.first_vertex = VW'(a);
		p.item.second_vertex = VW'(b);
		p.item.edge_slot = EW'(s);
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	function automatic plan_row_t opx(logic [1:0] act, int a, int b, int s, rsp_t want);
		plan_row_t p;
		p = op(act, a, b, s);
		p.typed = 1'b1;
		p.want = want;
		return p;
	endfunction

	function automatic plan_row_t reg_row(logic [1:0] idx, int v);
		plan_row_t p;
		p = op(ACT_ADD, 0, 0, 0);
		p.kind = ROW_REG;
		p.reg_idx = idx;
		p.value = v;
		return p;
	endfunction

	function automatic req_t random_item();
		req_t it;
		int r, n, m;
		n = model_vcount < MAX_V ? model_vcount : MAX_V;
		m = model_ecount < MAX_E ? model_ecount : MAX_E;
		r = $urandom_range(0, 9);
		it.action = r < 4 ? ACT_ADD : r < 6 ? ACT_DEGREE : r < 8 ? ACT_NEIGHBOR : ACT_ISOLATED;
		it.first_vertex = VW'($urandom);
		it.second_vertex = VW'($urandom);
		it.edge_slot = EW'($urandom);
		// mostly in range, the rest raw field values
		if ($urandom_range(0, 9) != 0) begin
			if (n > 0) begin
				it.first_vertex = VW'($urandom_range(0, n - 1));
				it.second_vertex = VW'($urandom_range(0, n - 1));
			end
			if (m > 0)
				it.edge_slot = EW'($urandom_range(0, m - 1));
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic predict_item(input req_t it, input bit typed, input rsp_t want);
		int n, m, va, vb, deg;
		bit iso;
		rsp_t r, hit;
		rsp_t outs [$];
		n = model_vcount < MAX_V ? model_vcount : MAX_V;
		m = model_ecount < MAX_E ? model_ecount : MAX_E;
		va = it.first_vertex;
		vb = it.second_vertex;
		r = done_rsp(1'b0, 1'b0);
		if (va >= n || (it.action == ACT_ADD && (vb >= n || int'(it.edge_slot) >= m))) begin
			r.index_error = 1'b1;
			outs = {outs, r};
		end else begin
			case (it.action)
				ACT_ADD: begin
					incidence[va][it.edge_slot] = ENT_POS;
					incidence[vb][it.edge_slot] = model_directed ? ENT_NEG : ENT_POS;
					outs = {outs, r};
				end
				ACT_DEGREE: begin
					deg = 0;
					for (int j = 0; j < m; j++)
						if (incidence[va][j] != ENT_ZERO &&
						    (!model_directed || incidence[va][j] == ENT_POS))
							deg++;
					r.degree_count = ECW'(deg);
					outs = {outs, r};
				end
				ACT_NEIGHBOR: begin
					for (int j = 0; j < m && outs.size() < RESULT_CAP; j++) begin
						if (incidence[va][j] == ENT_ZERO)
							continue;
						for (int i = 0; i < n; i++) begin
							if (i != va && incidence[i][j] != ENT_ZERO) begin
								hit = '0;
								hit.neighbor_found = 1'b1;
								hit.neighbor_vertex = VW'(i);
								outs = {outs, hit};
								break;
							end
						end
					end
					if (outs.size() == 0)
						outs = {outs, r};
					else
						outs[outs.size() - 1].last_result = 1'b1;
					if (outs.size() > longest_list)
						longest_list = outs.size();
				end
				default: begin
					iso = 1'b1;
					for (int j = 0; j < m; j++)
						if (incidence[va][j] != ENT_ZERO)
							iso = 1'b0;
					r.vertex_isolated = iso;
					outs = {outs, r};
				end
			endcase
		end
		if (typed)
			expected_rsps = {expected_rsps, want};
		else
			expected_rsps = {expected_rsps, outs};
	endtask

	task automatic send_item(input req_t it, input bit typed, input rsp_t want);
		int gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_item(it, typed, want);
		item_count++;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DIRECTED: model_directed = v[0];
			REG_VCOUNT:   model_vcount = int'(v[4:0]);
			REG_ECOUNT:   model_ecount = int'(v[5:0]);
			default: ;
		endcase
	endtask

	// receiver back-pressure: runs of stall and of free cycles
	always @(posedge clk) begin
		if (stall_hold > 0)
			stall_hold <= stall_hold - 1;
		else if (calm)
			rsp_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 35) begin
			rsp_stall <= 1'b1;
			stall_hold <= idle_len();
		end else begin
			rsp_stall <= 1'b0;
			stall_hold <= $urandom_range(0, 6);
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (expected_rsps.size() == 0)
				report_mismatch($sformatf("result with nothing expected: %p", rsp));
			else begin
				want = expected_rsps.pop_front();
				if (want.index_error)
					error_count++;
				if (rsp.degree_count !== want.degree_count)
					report_mismatch($sformatf("degree_count got %0d want %0d",
						rsp.degree_count, want.degree_count));
				if (rsp.neighbor_vertex !== want.neighbor_vertex)
					report_mismatch($sformatf("neighbor_vertex got %0d want %0d",
						rsp.neighbor_vertex, want.neighbor_vertex));
				if (rsp.neighbor_found !== want.neighbor_found)
					report_mismatch($sformatf("neighbor_found got %b want %b",
						rsp.neighbor_found, want.neighbor_found));
				if (rsp.vertex_isolated !== want.vertex_isolated)
					report_mismatch($sformatf("vertex_isolated got %b want %b",
						rsp.vertex_isolated, want.vertex_isolated));
				if (rsp.index_error !== want.index_error)
					report_mismatch($sformatf("index_error got %b want %b",
						rsp.index_error, want.index_error));
				if (rsp.last_result !== want.last_result)
					report_mismatch($sformatf("last_result got %b want %b",
						rsp.last_result, want.last_result));
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		setting_t settings [$];
		rsp_t ack;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		fail_count = 0;
		item_count = 0;
		rsp_count = 0;
		error_count = 0;
		longest_list = 0;
		setting_count = 1;
		model_directed = 1'b0;
		model_vcount = MAX_V;
		model_ecount = MAX_E;
		foreach (incidence[v, e])
			incidence[v][e] = ENT_ZERO;
		ack = done_rsp(1'b0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		plan = {
			opx(ACT_ISOLATED, 0, 0, 0, done_rsp(1'b1, 1'b0)),
			opx(ACT_DEGREE, 15, 3, 9, ack),
			opx(ACT_NEIGHBOR, 3, 0, 0, ack),
			opx(ACT_ADD, 0, 15, 31, ack),
			opx(ACT_ADD, 15, 15, 0, ack),       // self-loop
			opx(ACT_ADD, 0, 5, 0, ack),
			op(ACT_DEGREE, 0, 0, 0),
			op(ACT_NEIGHBOR, 0, 0, 0),
			op(ACT_NEIGHBOR, 15, 0, 0),
			op(ACT_ISOLATED, 15, 0, 0),
			reg_row(REG_DIRECTED, 1),
			opx(ACT_ADD, 3, 3, 7, ack),         // directed self-loop keeps -1
			op(ACT_DEGREE, 3, 0, 0),
			opx(ACT_ADD, 3, 9, 8, ack),
			op(ACT_DEGREE, 9, 0, 0),
			op(ACT_NEIGHBOR, 9, 0, 0),
			reg_row(REG_VCOUNT, 5),
			opx(ACT_DEGREE, 5, 0, 0, done_rsp(1'b0, 1'b1)),
			opx(ACT_ADD, 1, 5, 2, done_rsp(1'b0, 1'b1)),
			reg_row(REG_ECOUNT, 3),
			opx(ACT_ADD, 1, 2, 3, done_rsp(1'b0, 1'b1)),
			op(ACT_DEGREE, 3, 0, 0),
			reg_row(REG_VCOUNT, 0),
			opx(ACT_ISOLATED, 0, 0, 0, done_rsp(1'b0, 1'b1)),
			reg_row(REG_VCOUNT, 31),
			reg_row(REG_ECOUNT, 63),
			op(ACT_NEIGHBOR, 0, 0, 0),
			op(ACT_DEGREE, 15, 15, 31),
			reg_row(REG_ECOUNT, 0),
			opx(ACT_ISOLATED, 3, 0, 0, done_rsp(1'b1, 1'b0)),
			opx(ACT_ADD, 0, 1, 0, done_rsp(1'b0, 1'b1))
		};

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[k].reg_idx, plan[k].value);
				setting_count++;
			end else
				send_item(plan[k].item, plan[k].typed, plan[k].want);
		end

		settings = {
			setting_t'{1'b0, 16, 32, 40, 1'b0},
			setting_t'{1'b1, 4, 8, 40, 1'b0},
			setting_t'{1'b0, 2, 32, 40, 1'b1},  // dense columns, long neighbour lists
			setting_t'{1'b1, 16, 20, 40, 1'b0},
			setting_t'{1'b0, 31, 63, 40, 1'b0}
		};

		foreach (settings[s]) begin
			wait_idle();
			write_reg(REG_DIRECTED, 32'(settings[s].directed));
			write_reg(REG_VCOUNT, settings[s].vcount);
			write_reg(REG_ECOUNT, settings[s].ecount);
			calm = settings[s].calm;
			setting_count++;
			repeat (settings[s].items)
				send_item(random_item(), 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent across %0d register settings, %0d results compared",
			item_count, setting_count, rsp_count);
		$display("%0d index errors, longest neighbour list %0d", error_count, longest_list);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/gim_pkg.sv
rtl/gim_ctrl.sv
rtl/gim_dp.sv
rtl/graph_incidence_matrix_store.sv
rtl/gim_checker.sv
verif/tb_graph_incidence_matrix_store.sv
